[rtl/exp3_pkg.sv]
// Shared types, constants and tables for the EXP3 strategy selector.
// Used by every module of the block; depends on nothing.
package exp3_pkg;

    localparam int NUM_STRAT = 4;
    localparam int IDX_W     = 2;

    localparam logic [16:0] GAIN_ONE  = 17'd65536;
    localparam logic [20:0] X_SAT     = 21'd2031616;      // 31.0 in Q16.16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [40:0] RATIO_CAP = 41'h100_0000_0000; // 2^40
    localparam logic [47:0] TIME_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] W_RESET   = 32'(65536 / NUM_STRAT);
    localparam logic [31:0] P_RESET   = 32'(64'd2147483648 / NUM_STRAT);
    localparam logic [31:0] P_ONE_LSB = 32'd1;

    // shared divider geometry
    localparam int DIVD_W = 72;
    localparam int DIVS_W = 49;
    localparam int STEP_W = 7;
    localparam int MUL_W  = 34;

    localparam logic [STEP_W-1:0] STEPS_R     = 7'd47;
    localparam logic [STEP_W-1:0] STEPS_X     = 7'd72;
    localparam logic [STEP_W-1:0] STEPS_SHARE = 7'd63;
    localparam logic [STEP_W-1:0] STEPS_FACT  = 7'd49;
    localparam logic [STEP_W-1:0] STEPS_PROB  = 7'd63;

    typedef enum logic
    {
        REG_GAIN = 1'b0,
        REG_MAX  = 1'b1
    } reg_idx_t;

    typedef enum logic
    {
        FUNC_SAMPLE = 1'b0,
        FUNC_UPDATE = 1'b1
    } func_t;

    typedef struct packed
    {
        logic               func;
        logic [1:0]         strategy_index;
        logic [31:0]        time_used;
        logic signed [31:0] delta_value;
        logic [3:0]         exclude_mask;
        logic [31:0]        random_fraction;
    } cmd_t;

    typedef struct packed
    {
        logic [1:0] chosen_index;
        logic       none_left;
    } result_t;

    typedef struct packed
    {
        logic              start;
        logic [DIVD_W-1:0] dividend;   // left aligned on bit DIVD_W-1
        logic [DIVS_W-1:0] divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef enum logic [5:0]
    {
        ST_IDLE,
        ST_SEL_SUM,
        ST_TGT_MUL,
        ST_TGT,
        ST_SCAN,
        ST_CHARGE,
        ST_DIV_R,
        ST_T_LO,
        ST_T_HI,
        ST_T_SUM,
        ST_DIV_X,
        ST_Y_MUL,
        ST_Y,
        ST_EXP_MUL,
        ST_EXP_ACC,
        ST_W_MUL,
        ST_W_LOAD,
        ST_W_LZ,
        ST_W_APPLY,
        ST_WSUM,
        ST_SHARE,
        ST_DIV_SHARE,
        ST_A_MUL,
        ST_A,
        ST_DIV_FACT,
        ST_Q_MUL,
        ST_Q,
        ST_QNORM,
        ST_QRESUM,
        ST_PROB,
        ST_DIV_PROB
    } state_t;

    // 2^(2^-(i+1)) in Q1.31
    function automatic logic [31:0] pow2_frac(input logic [3:0] i);
        logic [31:0] v;
        begin
            case (i)
                4'd0:    v = 32'd3037000500;
                4'd1:    v = 32'd2553802834;
                4'd2:    v = 32'd2341847524;
                4'd3:    v = 32'd2242560872;
                4'd4:    v = 32'd2194507417;
                4'd5:    v = 32'd2170868214;
                4'd6:    v = 32'd2159144705;
                4'd7:    v = 32'd2153306050;
                4'd8:    v = 32'd2150392878;
                4'd9:    v = 32'd2148937771;
                4'd10:   v = 32'd2148210586;
                4'd11:   v = 32'd2147847086;
                4'd12:   v = 32'd2147665360;
                4'd13:   v = 32'd2147574502;
                4'd14:   v = 32'd2147529074;
                default: v = 32'd2147506361;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/exp3_strategy_selector_core.sv]
// EXP3 bandit strategy selector: top level sequencer and strategy tables.
// Depends on exp3_pkg, exp3_div, exp3_mul, exp3_cfg.
//
// Usage: drive cmd and raise start while busy is low; the command is taken at
// that clock edge and busy rises on the next cycle. The result appears on
// result for exactly one cycle with done high, and busy is low in that cycle,
// so the next command may be issued alongside it. The receiver cannot stall.
// A sample command (func 0) sums the allowed probabilities, multiplies the
// sum by random_fraction and scans the strategies for the pick; when every
// strategy is excluded it returns straight after the sum step. An update
// command (func 1) uses the one-bit-per-cycle shared divider for two
// divisions for the weight and three per strategy for the probabilities, and
// runs an exponent loop over the fraction bits, a leading-zero search and a
// probability rescaling. When the weight total or the probability total is
// zero the matching divisions are skipped. One command is in work at a time.
// Configuration goes through the APB port (gain at 0x0, value scale at 0x4)
// and must be written only while the block is idle; the block does not enforce it.
// Reset restores weights to 1/N, probabilities to 1/N, and clears time and
// use counts; no clearing pass is needed.
module exp3_strategy_selector_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  exp3_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output exp3_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int N = exp3_pkg::NUM_STRAT;
    localparam logic [exp3_pkg::IDX_W-1:0] LAST = exp3_pkg::IDX_W'(N - 1);

    exp3_pkg::state_t  state_reg, state_next;
    exp3_pkg::cmd_t    cmd_reg, cmd_next;
    exp3_pkg::result_t result_reg, result_next;
    logic              done_reg, done_next;

    logic [31:0] w_reg   [N];
    logic [31:0] w_next  [N];
    logic [31:0] p_reg   [N];
    logic [31:0] p_next  [N];
    logic [47:0] tim_reg [N];
    logic [47:0] tim_next[N];
    logic [31:0] cnt_reg [N];
    logic [31:0] cnt_next[N];
    logic [47:0] q_reg   [N];
    logic [47:0] q_next  [N];

    logic [exp3_pkg::IDX_W-1:0] i_reg, i_next;
    logic [3:0]  fbit_reg, fbit_next;
    logic [6:0]  lz_reg, lz_next;
    logic [40:0] r_reg, r_next;
    logic [48:0] acc_reg, acc_next;
    logic [20:0] x_reg, x_next;
    logic [21:0] y_reg, y_next;
    logic [31:0] m_reg, m_next;
    logic [63:0] keep_reg, keep_next;
    logic [63:0] norm_reg, norm_next;
    logic [33:0] wsum_reg, wsum_next;
    logic [31:0] share_reg, share_next;
    logic [31:0] a_reg, a_next;
    logic [32:0] factor_reg, factor_next;
    logic [49:0] qsum_reg, qsum_next;
    logic [33:0] sum_reg, sum_next;
    logic [33:0] tgt_reg, tgt_next;
    logic [33:0] cum_reg, cum_next;

    // shared units
    exp3_pkg::div_req_t          div_req;
    logic                        div_done;
    logic [exp3_pkg::DIVD_W-1:0] div_quo;
    logic [exp3_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [2*exp3_pkg::MUL_W-1:0] prod;
    logic [16:0] gain_cfg;
    logic [30:0] maxv_cfg;

    exp3_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    exp3_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    exp3_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gain    (gain_cfg),
        .maxv    (maxv_cfg)
    );

    // operand helpers
    logic [16:0] g_eff;
    logic [30:0] mx_eff;
    logic [1:0]  idx;
    logic [30:0] delta_pos;
    logic [31:0] p_eff;
    logic [48:0] time_sum;
    logic [57:0] t_sum;
    logic [33:0] sel_sum;
    logic [33:0] w_total;
    logic [49:0] q_total;
    logic [exp3_pkg::IDX_W-1:0] first_idx;
    logic        any_allowed;
    logic [33:0] cum_n;

    assign g_eff     = (gain_cfg > exp3_pkg::GAIN_ONE) ? exp3_pkg::GAIN_ONE : gain_cfg;
    assign mx_eff    = (maxv_cfg == '0) ? 31'd1 : maxv_cfg;
    assign idx       = cmd_reg.strategy_index;
    assign delta_pos = cmd_reg.delta_value[31] ? 31'd0 : cmd_reg.delta_value[30:0];
    assign p_eff     = (p_reg[idx] == '0) ? exp3_pkg::P_ONE_LSB : p_reg[idx];
    assign time_sum  = {1'b0, tim_reg[idx]} + 49'(cmd_reg.time_used);
    assign t_sum     = 58'(acc_reg) + {prod[25:0], 32'd0};
    assign cum_n     = cum_reg + 34'(p_reg[i_reg]);

    always_comb
    begin
        sel_sum     = '0;
        w_total     = '0;
        q_total     = '0;
        first_idx   = '0;
        any_allowed = 1'b0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (!cmd_reg.exclude_mask[k])
            begin
                sel_sum     = sel_sum + 34'(p_reg[k]);
                first_idx   = exp3_pkg::IDX_W'(k);
                any_allowed = 1'b1;
            end
            w_total = w_total + 34'(w_reg[k]);
            q_total = q_total + 50'(q_reg[k]);
        end
    end

    // weight rescale after the exponent multiply
    logic [5:0]        exp_k;
    logic [6:0]        bl;
    logic signed [8:0] len_s;
    logic signed [6:0] net_s;
    logic [6:0]        net_neg;
    logic [6:0]        sh;
    logic              wzero, ovf;
    logic [31:0]       v;

    assign exp_k   = y_reg[21:16];
    assign bl      = 7'd64 - lz_reg;
    assign len_s   = $signed({2'b00, bl}) + $signed({3'b000, exp_k}) - 9'sd31;
    assign net_s   = $signed({1'b0, exp_k}) - 7'sd31;
    assign net_neg = 7'(-net_s);
    assign sh      = 7'(len_s - 9'sd31);
    assign wzero   = (keep_reg == '0);
    assign ovf     = !wzero && (len_s > 9'sd31);

    always_comb
    begin
        if (wzero)
        begin
            v = '0;
        end
        else if (ovf)
        begin
            v = {1'b0, norm_reg[63:33]};
        end
        else if (!net_s[6])
        begin
            v = 32'(keep_reg << net_s[3:0]);
        end
        else
        begin
            v = 32'(keep_reg >> net_neg[4:0]);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        w_next      = w_reg;
        p_next      = p_reg;
        tim_next    = tim_reg;
        cnt_next    = cnt_reg;
        q_next      = q_reg;
        i_next      = i_reg;
        fbit_next   = fbit_reg;
        lz_next     = lz_reg;
        r_next      = r_reg;
        acc_next    = acc_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        m_next      = m_reg;
        keep_next   = keep_reg;
        norm_next   = norm_reg;
        wsum_next   = wsum_reg;
        share_next  = share_reg;
        a_next      = a_reg;
        factor_next = factor_reg;
        qsum_next   = qsum_reg;
        sum_next    = sum_reg;
        tgt_next    = tgt_reg;
        cum_next    = cum_reg;
        div_req     = '0;
        mul_a       = '0;
        mul_b       = '0;

        unique case (state_reg)
            exp3_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = (cmd.func == exp3_pkg::FUNC_UPDATE) ?
                                 exp3_pkg::ST_CHARGE : exp3_pkg::ST_SEL_SUM;
                end
            end

            // ---- sample ----
            exp3_pkg::ST_SEL_SUM:
            begin
                if (!any_allowed)
                begin
                    result_next.chosen_index = '0;
                    result_next.none_left    = 1'b1;
                    done_next                = 1'b1;
                    state_next               = exp3_pkg::ST_IDLE;
                end
                else
                begin
                    sum_next   = sel_sum;
                    state_next = exp3_pkg::ST_TGT_MUL;
                end
            end
            exp3_pkg::ST_TGT_MUL:
            begin
                mul_a      = 34'(cmd_reg.random_fraction);
                mul_b      = sum_reg;
                state_next = exp3_pkg::ST_TGT;
            end
            exp3_pkg::ST_TGT:
            begin
                tgt_next   = prod[65:32];
                cum_next   = '0;
                i_next     = '0;
                state_next = exp3_pkg::ST_SCAN;
            end
            exp3_pkg::ST_SCAN:
            begin
                i_next = i_reg + 1'b1;
                if (!cmd_reg.exclude_mask[i_reg])
                begin
                    cum_next = cum_n;
                end
                if (!cmd_reg.exclude_mask[i_reg] && (cum_n > tgt_reg))
                begin
                    result_next.chosen_index = i_reg;
                    result_next.none_left    = 1'b0;
                    done_next                = 1'b1;
                    state_next               = exp3_pkg::ST_IDLE;
                end
                else if (i_reg == LAST)
                begin
                    // all allowed strategies carry zero probability
                    result_next.chosen_index = first_idx;
                    result_next.none_left    = 1'b0;
                    done_next                = 1'b1;
                    state_next               = exp3_pkg::ST_IDLE;
                end
            end

            // ---- update: weight ----
            exp3_pkg::ST_CHARGE:
            begin
                tim_next[idx] = time_sum[48] ? exp3_pkg::TIME_MAX : time_sum[47:0];
                if (cnt_reg[idx] != 32'hFFFF_FFFF)
                begin
                    cnt_next[idx] = cnt_reg[idx] + 32'd1;
                end
                div_req.start    = 1'b1;
                div_req.dividend = {delta_pos, 41'd0};
                div_req.divisor  = 49'(mx_eff);
                div_req.steps    = exp3_pkg::STEPS_R;
                state_next       = exp3_pkg::ST_DIV_R;
            end
            exp3_pkg::ST_DIV_R:
            begin
                if (div_done)
                begin
                    r_next = (div_quo > 72'(exp3_pkg::RATIO_CAP)) ?
                             exp3_pkg::RATIO_CAP : div_quo[40:0];
                    state_next = exp3_pkg::ST_T_LO;
                end
            end
            exp3_pkg::ST_T_LO:
            begin
                mul_a      = 34'(g_eff);
                mul_b      = 34'(r_reg[31:0]);
                state_next = exp3_pkg::ST_T_HI;
            end
            exp3_pkg::ST_T_HI:
            begin
                acc_next   = prod[48:0];
                mul_a      = 34'(g_eff);
                mul_b      = 34'(r_reg[40:32]);
                state_next = exp3_pkg::ST_T_SUM;
            end
            exp3_pkg::ST_T_SUM:
            begin
                // x = t * 2^14 / p, saturated afterwards
                div_req.start    = 1'b1;
                div_req.dividend = {t_sum, 14'd0};
                div_req.divisor  = 49'(p_eff);
                div_req.steps    = exp3_pkg::STEPS_X;
                state_next       = exp3_pkg::ST_DIV_X;
            end
            exp3_pkg::ST_DIV_X:
            begin
                if (div_done)
                begin
                    x_next = (div_quo > 72'(exp3_pkg::X_SAT)) ?
                             exp3_pkg::X_SAT : div_quo[20:0];
                    state_next = exp3_pkg::ST_Y_MUL;
                end
            end
            exp3_pkg::ST_Y_MUL:
            begin
                mul_a      = 34'(x_reg);
                mul_b      = 34'(exp3_pkg::LOG2E_Q16);
                state_next = exp3_pkg::ST_Y;
            end
            exp3_pkg::ST_Y:
            begin
                y_next     = prod[37:16];
                m_next     = 32'h8000_0000;
                fbit_next  = '0;
                state_next = exp3_pkg::ST_EXP_MUL;
            end
            exp3_pkg::ST_EXP_MUL:
            begin
                mul_a      = 34'(m_reg);
                mul_b      = 34'(exp3_pkg::pow2_frac(fbit_reg));
                state_next = exp3_pkg::ST_EXP_ACC;
            end
            exp3_pkg::ST_EXP_ACC:
            begin
                // fraction bits from the MSB down
                if (y_reg[4'd15 - fbit_reg])
                begin
                    m_next = prod[62:31];
                end
                fbit_next  = fbit_reg + 1'b1;
                state_next = (fbit_reg == 4'd15) ? exp3_pkg::ST_W_MUL : exp3_pkg::ST_EXP_MUL;
            end
            exp3_pkg::ST_W_MUL:
            begin
                mul_a      = 34'(w_reg[idx]);
                mul_b      = 34'(m_reg);
                state_next = exp3_pkg::ST_W_LOAD;
            end
            exp3_pkg::ST_W_LOAD:
            begin
                keep_next  = prod[63:0];
                norm_next  = prod[63:0];
                lz_next    = '0;
                state_next = (prod[63:0] == '0) ? exp3_pkg::ST_W_APPLY : exp3_pkg::ST_W_LZ;
            end
            exp3_pkg::ST_W_LZ:
            begin
                if (norm_reg[63])
                begin
                    state_next = exp3_pkg::ST_W_APPLY;
                end
                else
                begin
                    norm_next = {norm_reg[62:0], 1'b0};
                    lz_next   = lz_reg + 7'd1;
                end
            end
            exp3_pkg::ST_W_APPLY:
            begin
                if (ovf)
                begin
                    for (int k = 0; k < N; k++)
                    begin
                        w_next[k] = (sh >= 7'd32) ? 32'd0 : (w_reg[k] >> sh[4:0]);
                    end
                end
                w_next[idx] = v;
                state_next  = exp3_pkg::ST_WSUM;
            end

            // ---- update: probabilities ----
            exp3_pkg::ST_WSUM:
            begin
                wsum_next  = w_total;
                qsum_next  = '0;
                i_next     = '0;
                state_next = exp3_pkg::ST_SHARE;
            end
            exp3_pkg::ST_SHARE:
            begin
                if (wsum_reg == '0)
                begin
                    share_next = '0;
                    state_next = exp3_pkg::ST_A_MUL;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {w_reg[i_reg], 40'd0};
                    div_req.divisor  = 49'(wsum_reg);
                    div_req.steps    = exp3_pkg::STEPS_SHARE;
                    state_next       = exp3_pkg::ST_DIV_SHARE;
                end
            end
            exp3_pkg::ST_DIV_SHARE:
            begin
                if (div_done)
                begin
                    share_next = div_quo[31:0];
                    state_next = exp3_pkg::ST_A_MUL;
                end
            end
            exp3_pkg::ST_A_MUL:
            begin
                mul_a      = 34'(exp3_pkg::GAIN_ONE - g_eff);
                mul_b      = 34'(share_reg);
                state_next = exp3_pkg::ST_A;
            end
            exp3_pkg::ST_A:
            begin
                a_next           = 32'(prod[48:16]) + 32'({g_eff, 14'd0});
                div_req.start    = 1'b1;
                div_req.dividend = {33'(cnt_reg[i_reg]) + 33'd1, 39'd0};
                div_req.divisor  = 49'(tim_reg[i_reg]) + 49'd65536;
                div_req.steps    = exp3_pkg::STEPS_FACT;
                state_next       = exp3_pkg::ST_DIV_FACT;
            end
            exp3_pkg::ST_DIV_FACT:
            begin
                if (div_done)
                begin
                    factor_next = div_quo[32:0];
                    state_next  = exp3_pkg::ST_Q_MUL;
                end
            end
            exp3_pkg::ST_Q_MUL:
            begin
                mul_a      = 34'(a_reg);
                mul_b      = 34'(factor_reg);
                state_next = exp3_pkg::ST_Q;
            end
            exp3_pkg::ST_Q:
            begin
                q_next[i_reg] = prod[63:16];
                qsum_next     = qsum_reg + 50'(prod[63:16]);
                i_next        = i_reg + 1'b1;
                state_next    = (i_reg == LAST) ? exp3_pkg::ST_QNORM : exp3_pkg::ST_SHARE;
            end
            exp3_pkg::ST_QNORM:
            begin
                // shift all terms together until the total fits 32 bits
                if (qsum_reg[49:32] != '0)
                begin
                    qsum_next = qsum_reg >> 1;
                    for (int k = 0; k < N; k++)
                    begin
                        q_next[k] = q_reg[k] >> 1;
                    end
                end
                else
                begin
                    state_next = exp3_pkg::ST_QRESUM;
                end
            end
            exp3_pkg::ST_QRESUM:
            begin
                qsum_next = q_total;
                i_next    = '0;
                if (q_total == '0)
                begin
                    for (int k = 0; k < N; k++)
                    begin
                        p_next[k] = exp3_pkg::P_RESET;
                    end
                    result_next = '0;
                    done_next   = 1'b1;
                    state_next  = exp3_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = exp3_pkg::ST_PROB;
                end
            end
            exp3_pkg::ST_PROB:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {q_reg[i_reg][31:0], 40'd0};
                div_req.divisor  = 49'(qsum_reg[31:0]);
                div_req.steps    = exp3_pkg::STEPS_PROB;
                state_next       = exp3_pkg::ST_DIV_PROB;
            end
            exp3_pkg::ST_DIV_PROB:
            begin
                if (div_done)
                begin
                    p_next[i_reg] = div_quo[31:0];
                    i_next        = i_reg + 1'b1;
                    if (i_reg == LAST)
                    begin
                        result_next = '0;
                        done_next   = 1'b1;
                        state_next  = exp3_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = exp3_pkg::ST_PROB;
                    end
                end
            end
            default:
            begin
                state_next = exp3_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= exp3_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= '0;
            fbit_reg  <= '0;
            lz_reg    <= '0;
            for (int k = 0; k < N; k++)
            begin
                w_reg[k]   <= exp3_pkg::W_RESET;
                p_reg[k]   <= exp3_pkg::P_RESET;
                tim_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            i_reg     <= i_next;
            fbit_reg  <= fbit_next;
            lz_reg    <= lz_next;
            w_reg     <= w_next;
            p_reg     <= p_next;
            tim_reg   <= tim_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        m_reg      <= m_next;
        keep_reg   <= keep_next;
        norm_reg   <= norm_next;
        wsum_reg   <= wsum_next;
        share_reg  <= share_next;
        a_reg      <= a_next;
        factor_reg <= factor_next;
        qsum_reg   <= qsum_next;
        sum_reg    <= sum_next;
        tgt_reg    <= tgt_next;
        cum_reg    <= cum_next;
    end

    assign busy   = (state_reg != exp3_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    ap_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result transfer while a command is in work");

    ap_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    ap_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.none_left) |-> (result.chosen_index == '0))
        else $error("none_left result carries a nonzero index");

    ap_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == exp3_pkg::ST_DIV_R || state_reg == exp3_pkg::ST_DIV_X ||
                      state_reg == exp3_pkg::ST_DIV_SHARE ||
                      state_reg == exp3_pkg::ST_DIV_FACT ||
                      state_reg == exp3_pkg::ST_DIV_PROB))
        else $error("divider finished outside a wait state");

endmodule

[rtl/exp3_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on exp3_pkg (div_req_t, widths).
module exp3_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  exp3_pkg::div_req_t        req,
    output logic                      done,
    output logic [exp3_pkg::DIVD_W-1:0] quo
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [exp3_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [exp3_pkg::DIVS_W-1:0]   rem_reg, rem_next;
    logic [exp3_pkg::DIVS_W-1:0]   dsr_reg, dsr_next;
    logic [exp3_pkg::DIVD_W-1:0]   dvd_reg, dvd_next;
    logic [exp3_pkg::DIVS_W:0]     rem_sh;
    logic [exp3_pkg::DIVS_W+1:0]   diff;
    logic                          ge;

    assign rem_sh = {rem_reg, dvd_reg[exp3_pkg::DIVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dsr_reg};
    assign ge     = !diff[exp3_pkg::DIVS_W+1];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = req.steps;
            rem_next = '0;
            dsr_next = req.divisor;
            dvd_next = req.dividend;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[exp3_pkg::DIVS_W-1:0] : rem_sh[exp3_pkg::DIVS_W-1:0];
            // quotient bits fill in from the bottom as dividend bits leave the top
            dvd_next = {dvd_reg[exp3_pkg::DIVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 7'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
    end

    assign done = done_reg;
    assign quo  = dvd_reg;

endmodule

[rtl/exp3_mul.sv]
// Shared unsigned multiplier with a registered product.
// Depends on exp3_pkg (MUL_W).
module exp3_mul
(
    input  logic                         clk,
    input  logic [exp3_pkg::MUL_W-1:0]   a,
    input  logic [exp3_pkg::MUL_W-1:0]   b,
    output logic [2*exp3_pkg::MUL_W-1:0] prod
);

    logic [2*exp3_pkg::MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

[rtl/exp3_cfg.sv]
// APB-style register file: exploration gain and value scale.
// Depends on exp3_pkg (register indexes).
module exp3_cfg
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [16:0] gain,
    output logic [30:0] maxv
);

    logic [16:0] gain_reg, gain_next;
    logic [30:0] maxv_reg, maxv_next;
    logic        wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        gain_next = gain_reg;
        maxv_next = maxv_reg;
        prdata    = '0;
        unique case (exp3_pkg::reg_idx_t'(paddr[2]))
            exp3_pkg::REG_GAIN:
            begin
                prdata = {15'd0, gain_reg};
                if (wr)
                begin
                    gain_next = pwdata[16:0];
                end
            end
            exp3_pkg::REG_MAX:
            begin
                prdata = {1'b0, maxv_reg};
                if (wr)
                begin
                    maxv_next = pwdata[30:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= 17'd6554;
            maxv_reg <= 31'd65536;
        end
        else
        begin
            gain_reg <= gain_next;
            maxv_reg <= maxv_next;
        end
    end

    assign gain = gain_reg;
    assign maxv = maxv_reg;

endmodule

[tb/tb_exp3_strategy_selector_core.sv]
// Self-checking testbench for the EXP3 strategy selector core.
// Predicts each sample/update result from a local fixed-point model of the tables.
// Depends on exp3_pkg and exp3_strategy_selector_core.
module tb_exp3_strategy_selector_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int N_RANDOM    = 1300;
    localparam int NS          = exp3_pkg::NUM_STRAT;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    exp3_pkg::cmd_t       cmd;
    logic                 busy;
    logic                 done;
    exp3_pkg::result_t    result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    exp3_strategy_selector_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // selector model state
    logic [16:0] gain_q;
    logic [30:0] scale_q;
    logic [31:0] weight_q [NS];
    logic [31:0] prob_q   [NS];
    logic [47:0] spent_q  [NS];
    logic [31:0] uses_q   [NS];

    exp3_pkg::cmd_t    pending_cmds [$];
    exp3_pkg::result_t expected_results [$];
    int      err_count;
    int      checked;
    int      n_samples;
    int      n_updates;
    longint  cycles;
    int      gap_left;
    int      burst_left;

    localparam logic [31:0] EXP_TABLE [16] = '{
        32'd3037000500, 32'd2553802834, 32'd2341847524, 32'd2242560872,
        32'd2194507417, 32'd2170868214, 32'd2159144705, 32'd2153306050,
        32'd2150392878, 32'd2148937771, 32'd2148210586, 32'd2147847086,
        32'd2147665360, 32'd2147574502, 32'd2147529074, 32'd2147506361
    };

    function automatic int bitlen(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) n = i + 1;
        return n;
    endfunction

    task automatic model_reset();
        gain_q  = 17'd6554;
        scale_q = 31'd65536;
        for (int i = 0; i < NS; i++)
        begin
            weight_q[i] = 32'd65536 / NS;
            prob_q[i]   = 32'h8000_0000 / NS;
            spent_q[i]  = '0;
            uses_q[i]   = '0;
        end
    endtask

    task automatic apply_update(input int idx, input logic [31:0] t_in,
                                input logic [31:0] d_in);
        logic [63:0] g, mx, delta, r, t, p, x, y, m, prod, v, wsum, qsum, quo;
        logic [63:0] share, a, factor;
        logic [63:0] q [NS];
        logic [64:0] tsum;
        int k, f, bl, sh, net, len;
        g = (gain_q > exp3_pkg::GAIN_ONE) ? 64'd65536 : 64'(gain_q);
        mx = (scale_q != 0) ? 64'(scale_q) : 64'd1;
        delta = d_in[31] ? 64'd0 : 64'(d_in);
        x = 0; wsum = 0; qsum = 0; sh = 0;
        tsum = 65'(spent_q[idx]) + 65'(t_in);
        spent_q[idx] = (tsum > 65'(exp3_pkg::TIME_MAX)) ? exp3_pkg::TIME_MAX : tsum[47:0];
        if (uses_q[idx] != 32'hFFFF_FFFF) uses_q[idx]++;
        r = (delta << 16) / mx;
        if (r > 64'(exp3_pkg::RATIO_CAP)) r = 64'(exp3_pkg::RATIO_CAP);
        t = g * r;
        p = (prob_q[idx] != 0) ? 64'(prob_q[idx]) : 64'd1;
        if (t != 0)
        begin
            quo = t / p;
            if (quo >= 64'd2097152) x = 64'(exp3_pkg::X_SAT);
            else x = (quo << 14) + (((t % p) << 14) / p);
            if (x > 64'(exp3_pkg::X_SAT)) x = 64'(exp3_pkg::X_SAT);
        end
        y = (x * 64'(exp3_pkg::LOG2E_Q16)) >> 16;
        k = int'(y >> 16);
        f = int'(y & 64'hFFFF);
        m = 64'h8000_0000;
        for (int i = 0; i < 16; i++)
            if ((f >> (15 - i)) & 1) m = (m * 64'(EXP_TABLE[i])) >> 31;
        prod = 64'(weight_q[idx]) * m;
        if (prod == 0)
            v = 0;
        else
        begin
            bl = bitlen(prod);
            len = bl + k - 31;
            if (len > 31) sh = len - 31;
            net = k - 31 - sh;
            v = (net >= 0) ? (prod << net) : (prod >> (-net));
        end
        if (sh > 0)
            for (int i = 0; i < NS; i++)
                weight_q[i] = (sh >= 32) ? 32'd0 : (weight_q[i] >> sh);
        weight_q[idx] = v[31:0];
        for (int i = 0; i < NS; i++) wsum += 64'(weight_q[i]);
        for (int i = 0; i < NS; i++)
        begin
            share = (wsum != 0) ? ((64'(weight_q[i]) << 31) / wsum) : 64'd0;
            a = (((64'd65536 - g) * share) >> 16) + (g << 14);
            factor = ((64'(uses_q[i]) + 1) << 16) / (64'(spent_q[i]) + 64'd65536);
            q[i] = (a * factor) >> 16;
            qsum += q[i];
        end
        bl = bitlen(qsum) - 32;
        if (bl > 0)
        begin
            qsum = 0;
            for (int i = 0; i < NS; i++)
            begin
                q[i] = q[i] >> bl;
                qsum += q[i];
            end
        end
        for (int i = 0; i < NS; i++)
            prob_q[i] = (qsum == 0) ? (32'h8000_0000 / NS)
                                    : 32'((q[i] << 31) / qsum);
    endtask

    function automatic exp3_pkg::result_t pick_strategy(input exp3_pkg::cmd_t c);
        exp3_pkg::result_t res;
        logic [63:0] sum, target, cum, rnd;
        int first, pick;
        res = '0;
        sum = 0; cum = 0; first = -1; pick = -1;
        rnd = 64'(c.random_fraction);
        for (int i = 0; i < NS; i++)
            if (!c.exclude_mask[i])
            begin
                if (first < 0) first = i;
                sum += 64'(prob_q[i]);
            end
        if (first < 0)
        begin
            res.none_left = 1'b1;
            return res;
        end
        target = rnd * (sum >> 32) + ((rnd * (sum & 64'hFFFF_FFFF)) >> 32);
        for (int i = 0; i < NS; i++)
            if (!c.exclude_mask[i] && pick < 0)
            begin
                cum += 64'(prob_q[i]);
                if (cum > target) pick = i;
            end
        if (pick < 0) pick = first;
        res.chosen_index = 2'(pick);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic exp3_pkg::cmd_t rand_cmd(input bit upd);
        exp3_pkg::cmd_t c;
        c.func = upd ? exp3_pkg::FUNC_UPDATE : exp3_pkg::FUNC_SAMPLE;
        c.strategy_index = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       c.time_used = '0;
            1:       c.time_used = $urandom;
            default: c.time_used = $urandom_range(0, 32'h0010_0000);
        endcase
        case ($urandom_range(0, 4))
            0:       c.delta_value = $urandom;
            1:       c.delta_value = -$signed(32'($urandom_range(0, 65536)));
            default: c.delta_value = $urandom_range(0, 32'h0002_0000);
        endcase
        c.exclude_mask = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
        c.random_fraction = $urandom;
        return c;
    endfunction

    // clock, cycle counter and timeout
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // driver: bursts of transfers separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                // command on cmd was taken at an earlier rising edge and busy has fallen since
            end
            if (!(start && busy))
            begin
                if (gap_left > 0 || pending_cmds.size() == 0)
                begin
                    start <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end
                else
                begin
                    start <= 1'b1;
                    cmd   <= pending_cmds[0];
                end
            end
        end
    end

    // acceptance tracking and predictions at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            void'(pending_cmds.pop_front());
            if (cmd.func == exp3_pkg::FUNC_UPDATE)
            begin
                n_updates++;
                apply_update(int'(cmd.strategy_index), cmd.time_used, cmd.delta_value);
                expected_results.insert(expected_results.size(), exp3_pkg::result_t'('0));
            end
            else
            begin
                n_samples++;
                expected_results.insert(expected_results.size(), pick_strategy(cmd));
            end
            if (burst_left > 0)
                burst_left <= burst_left - 1;
            else
            begin
                burst_left <= $urandom_range(0, 12);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        exp3_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", int'(result), -1);
            else
            begin
                want = expected_results.pop_front();
                checked++;
                if (result.chosen_index !== want.chosen_index)
                    report_mismatch("chosen_index", int'(result.chosen_index),
                                    int'(want.chosen_index));
                if (result.none_left !== want.none_left)
                    report_mismatch("none_left", int'(result.none_left),
                                    int'(want.none_left));
            end
        end
    end

    task automatic reg_write(input exp3_pkg::reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(int'(idx) * 4); pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == exp3_pkg::REG_GAIN) gain_q = val[16:0];
        else scale_q = val[30:0];
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || start)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic add_update(input int idx, input logic [31:0] tm, input logic [31:0] d);
        exp3_pkg::cmd_t c;
        c = '0;
        c.func = exp3_pkg::FUNC_UPDATE;
        c.strategy_index = 2'(idx);
        c.time_used = tm;
        c.delta_value = d;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic add_sample(input logic [3:0] mask, input logic [31:0] rnd);
        exp3_pkg::cmd_t c;
        c = '0;
        c.func = exp3_pkg::FUNC_SAMPLE;
        c.exclude_mask = mask;
        c.random_fraction = rnd;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    initial
    begin
        logic [31:0] gains [5];
        logic [31:0] scales [5];
        rst_n = 1'b0; start = 1'b0; cmd = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        err_count = 0; checked = 0; n_samples = 0; n_updates = 0;
        cycles = 0; gap_left = 0; burst_left = 0;
        model_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset-state samples, mask extremes, all-excluded
        add_sample(4'h0, 32'h0);
        add_sample(4'h0, 32'hFFFF_FFFF);
        add_sample(4'hF, 32'h1234_5678);
        add_sample(4'hE, 32'h8000_0000);
        add_sample(4'h7, 32'hFFFF_FFFF);
        // updates: negative delta, zero, max time, huge ratio
        add_update(0, 32'h0, 32'h8000_0000);
        add_update(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        add_update(2, 32'h0001_0000, 32'h0);
        add_update(3, 32'h0, 32'h7FFF_FFFF);
        add_update(3, 32'h0, 32'h7FFF_FFFF);
        add_sample(4'h5, 32'h4000_0000);
        add_sample(4'hA, 32'hC000_0000);
        wait_drained();

        // gain above one, smallest scale: drives weight overflow and zero probs
        reg_write(exp3_pkg::REG_GAIN, 32'h1FFFF);
        reg_write(exp3_pkg::REG_MAX, 32'h0);
        add_update(0, 32'h0, 32'h7FFF_FFFF);
        add_update(1, 32'h0, 32'h7FFF_FFFF);
        add_update(0, 32'h0, 32'h7FFF_FFFF);
        add_sample(4'h0, 32'h9000_0000);
        add_sample(4'h1, 32'hFFFF_FFFF);
        wait_drained();
        reg_write(exp3_pkg::REG_GAIN, 32'h0);
        add_update(2, 32'hFFFF_FFFF, 32'h0001_0000);
        add_sample(4'h0, 32'h0000_0001);
        wait_drained();
        reg_write(exp3_pkg::REG_GAIN, 32'd65536);
        reg_write(exp3_pkg::REG_MAX, 32'h7FFF_FFFF);
        add_update(1, 32'h0, 32'h7FFF_FFFF);
        add_sample(4'h0, 32'h7FFF_FFFF);
        wait_drained();

        gains  = '{32'd6554, 32'd0, 32'd65536, 32'd30000, 32'd1000};
        scales = '{32'd65536, 32'd1, 32'h7FFF_FFFF, 32'd655360, 32'd16384};
        for (int ph = 0; ph < 5; ph++)
        begin
            reg_write(exp3_pkg::REG_GAIN, gains[ph]);
            reg_write(exp3_pkg::REG_MAX, scales[ph]);
            for (int n = 0; n < N_RANDOM / 5; n++)
                pending_cmds.insert(pending_cmds.size(), rand_cmd($urandom_range(0, 2) == 0));
            wait_drained();
        end

        $display("Checked %0d results: %0d samples, %0d updates", checked, n_samples, n_updates);
        $display("Gain and scale swept through several settings, including the clamped ones");
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[sim.f]
rtl/exp3_pkg.sv
rtl/exp3_div.sv
rtl/exp3_mul.sv
rtl/exp3_cfg.sv
rtl/exp3_strategy_selector_core.sv
tb/tb_exp3_strategy_selector_core.sv
